// File: rtl/core/key_slot_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Key slot table assertion macros
// Shared concurrent assertion forms for the key slot table RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_SLOT_TABLE_UNIT_ASSERT_SVH
`define KEY_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/kst_pkg.sv
// ----------------------------------------------------------------------------
// Key slot table package
// Operation and status codes, cell command type and fixed limits.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int FUNC_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int OUT_ID_W   = 16;
   localparam int OUT_DATA_W = 64;
   localparam int KCOUNT_W   = 5;
   localparam int MAX_RESULTS = 16;
   localparam int FOUND_W    = 5;

   localparam logic [FUNC_W-1:0] OP_INJECT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_ERASE  = 3'd1;
   localparam logic [FUNC_W-1:0] OP_UPDATE = 3'd2;
   localparam logic [FUNC_W-1:0] OP_GET    = 3'd3;
   localparam logic [FUNC_W-1:0] OP_LIST   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP_ID   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUP_DATA = 3'd5;

   typedef struct packed {
      logic inject;
      logic erase;
      logic update;
      logic rotate;
   } cell_cmd_type;

endpackage

// File: rtl/core/key_slot_table_unit.sv
// ----------------------------------------------------------------------------
// Key slot table unit
// Content-addressable key store built from a row of slot cells.
// ----------------------------------------------------------------------------
// Requests enter on req_t*, one transfer per request; results leave on rsp_t*
// with rsp_tlast set on the final result of a request. A result register sits
// on the output, so the next request is taken while a result waits.
// Inject, erase, update and get register the request, then do the parallel
// match across all cells and write-back as the result loads, which waits for
// a free result register. Another request is taken the cycle after the load.
// List rotates the cell row one slot per cycle past the head cell and emits
// each stored id in slot order (at most 16 results), or one zero-id result
// when none is stored; the scan covers every slot of the cell row once.
// While a result waits with rsp_tready low, the rotation and the result
// register hold.
// Reset frees every slot and clears the key count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "key_slot_table_unit_assert.svh"

module key_slot_table_unit #(
   parameter int SLOTS     = 16,
   parameter int ID_BITS   = 16,
   parameter int DATA_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [18:3] key_id, [82:19] key_data, [87:83] zero
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [18:3] out_id, [82:19] out_data, [87:83] key_count
   output logic [87:0] rsp_tdata,
   output logic        rsp_tlast
);
   import kst_pkg::*;

   localparam int ID_W   = (ID_BITS < OUT_ID_W) ? ID_BITS : OUT_ID_W;
   localparam int DATA_W = DATA_BITS;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [FOUND_W-1:0]  found_ff, found_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]     pend_id_ff, pend_id_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OUT_ID_W-1:0] oid_ff, oid_in;
   logic [OUT_DATA_W-1:0] odata_ff, odata_in;
   logic [KCOUNT_W-1:0] kcount_ff, kcount_in;
   logic                last_ff, last_in;

   logic                req_xfer;
   logic                out_free;
   logic                load;
   cell_cmd_type        cmd;

   logic                free_chain [SLOTS+1];
   logic                hit_chain  [SLOTS+1];
   logic [DATA_W-1:0]   hdata_chain [SLOTS+1];
   logic [ID_W-1:0]     cell_id   [SLOTS];
   logic [DATA_W-1:0]   cell_data [SLOTS];

   logic                head_used;
   logic                take;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign free_chain[0]  = 1'b0;
   assign hit_chain[0]   = 1'b0;
   assign hdata_chain[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      localparam int NXT = (i + 1) % SLOTS;
      kst_cell #(
         .ID_W   (ID_W),
         .DATA_W (DATA_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .req_id        (id_ff),
         .req_data      (data_ff),
         .free_seen_in  (free_chain[i]),
         .hit_in        (hit_chain[i]),
         .hit_data_in   (hdata_chain[i]),
         .nbr_id        (cell_id[NXT]),
         .nbr_data      (cell_data[NXT]),
         .free_seen_out (free_chain[i+1]),
         .hit_out       (hit_chain[i+1]),
         .hit_data_out  (hdata_chain[i+1]),
         .id_out        (cell_id[i]),
         .data_out      (cell_data[i])
      );
   end

   assign head_used = (cell_id[0] != '0);
   assign take      = head_used && (found_ff < FOUND_W'(MAX_RESULTS));

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      cmd           = '0;
      load          = 1'b0;
      status_in     = ST_OK;
      oid_in        = '0;
      odata_in      = '0;
      last_in       = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               func_in       = req_tdata[2:0];
               id_in         = req_tdata[3 +: ID_W];
               data_in       = req_tdata[19 +: DATA_W];
               step_in       = '0;
               found_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = (req_tdata[2:0] == OP_LIST) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (func_ff)
               OP_INJECT: begin
                  if (id_ff == '0) begin
                     status_in = ST_BAD_ID;
                  end else if (count_ff >= CNT_W'(SLOTS)) begin
                     status_in = ST_FULL;
                  end else if (hit_chain[SLOTS]) begin
                     status_in = ST_DUP_ID;
                  end else if (data_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.inject = out_free;
                     count_in   = count_ff + 1'b1;
                  end
               end
               OP_ERASE: begin
                  if (hit_chain[SLOTS]) begin
                     cmd.erase = out_free;
                     count_in  = count_ff - 1'b1;
                  end else begin
                     status_in = ST_BAD_ID;
                  end
               end
               OP_UPDATE: begin
                  if (data_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (!hit_chain[SLOTS]) begin
                     status_in = ST_BAD_ID;
                  end else if (hdata_chain[SLOTS] == data_ff) begin
                     status_in = ST_DUP_DATA;
                  end else begin
                     cmd.update = out_free;
                  end
               end
               OP_GET: begin
                  if (hit_chain[SLOTS]) begin
                     odata_in = OUT_DATA_W'(hdata_chain[SLOTS]);
                  end else begin
                     status_in = ST_BAD_ID;
                  end
               end
               default: begin
                  status_in = ST_BAD_ID;
               end
            endcase
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               count_in = count_ff;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               cmd.rotate = 1'b1;
               step_in    = step_ff + 1'b1;
               if (take) begin
                  // hold the newest id back until we know whether it is the last
                  load          = pend_valid_ff;
                  last_in       = 1'b0;
                  oid_in        = OUT_ID_W'(pend_id_ff);
                  pend_valid_in = 1'b1;
                  pend_id_in    = cell_id[0];
                  found_in      = found_ff + 1'b1;
               end
               if (step_ff == STEP_W'(SLOTS - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            oid_in = pend_valid_ff ? OUT_ID_W'(pend_id_ff) : '0;
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      kcount_in = KCOUNT_W'(count_in);
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         step_ff       <= '0;
         found_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      id_ff      <= id_in;
      data_ff    <= data_in;
      pend_id_ff <= pend_id_in;
      if (load) begin
         status_ff <= status_in;
         oid_ff    <= oid_in;
         odata_ff  <= odata_in;
         kcount_ff <= kcount_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {kcount_ff, odata_ff, oid_ff, status_ff};
   assign rsp_tlast  = last_ff;

   `KST_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(SLOTS),
      "key count exceeds slot count")
   `KST_ASSERT_NEXT(a_exec_result, clock, reset, (state_ff == ST_EXEC) && out_free,
      rsp_valid_ff && last_ff && (state_ff == ST_IDLE), "single result not loaded as last")
   `KST_ASSERT_IMPL(a_found_bound, clock, reset, 1'b1,
      found_ff <= FOUND_W'(MAX_RESULTS), "list emitted too many ids")
   `KST_ASSERT_IMPL(a_scan_idle_in, clock, reset, state_ff != ST_IDLE, !req_tready,
      "request taken while a request is in progress")

endmodule

// File: rtl/core/kst_cell.sv
// ----------------------------------------------------------------------------
// Key slot cell
// One slot of the table: id and data, parallel match, first-free and hit
// chains, and a rotate path to its neighbor for listing.
// ----------------------------------------------------------------------------
module kst_cell #(
   parameter int ID_W   = 16,
   parameter int DATA_W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kst_pkg::cell_cmd_type cmd,
   input  logic [ID_W-1:0]       req_id,
   input  logic [DATA_W-1:0]     req_data,
   input  logic                  free_seen_in,
   input  logic                  hit_in,
   input  logic [DATA_W-1:0]     hit_data_in,
   input  logic [ID_W-1:0]       nbr_id,
   input  logic [DATA_W-1:0]     nbr_data,
   output logic                  free_seen_out,
   output logic                  hit_out,
   output logic [DATA_W-1:0]     hit_data_out,
   output logic [ID_W-1:0]       id_out,
   output logic [DATA_W-1:0]     data_out
);
   import kst_pkg::*;

   logic [ID_W-1:0]   id_ff, id_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              occupied;
   logic              first_free;
   logic              match;

   assign occupied      = (id_ff != '0);
   assign first_free    = !occupied && !free_seen_in;
   assign free_seen_out = free_seen_in || !occupied;
   assign match         = occupied && (id_ff == req_id);
   assign hit_out       = hit_in || match;
   assign hit_data_out  = hit_data_in | (match ? data_ff : '0);
   assign id_out        = id_ff;
   assign data_out      = data_ff;

   always_comb begin
      id_in   = id_ff;
      data_in = data_ff;
      if (cmd.rotate) begin
         id_in   = nbr_id;
         data_in = nbr_data;
      end else if (cmd.inject && first_free) begin
         id_in   = req_id;
         data_in = req_data;
      end else if (cmd.erase && match) begin
         id_in   = '0;
         data_in = '0;
      end else if (cmd.update && match) begin
         data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= '0;
      end else begin
         id_ff <= id_in;
      end
   end

   // free slots are never matched, so their data needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: test/key_slot_table_unit_test.sv
// ----------------------------------------------------------------------------
// Key slot table unit testbench
// Drives inject, erase, update, get and list requests into the key store and
// checks every result against a slot-level model kept alongside. A directed
// table covers the id-zero, empty-data, duplicate, unknown-operation and list
// cases; random phases then fill and drain the table under varying stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_slot_table_unit_test;
   import kst_pkg::*;

   localparam int SLOTS     = 16;
   localparam int ID_POOL_N = 20;
   localparam int RAND_N    = 68;

   // unused operation codes, answered with an invalid-id status
   localparam logic [FUNC_W-1:0] OP_SPARE5 = 3'd5;
   localparam logic [FUNC_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [FUNC_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [OUT_ID_W-1:0]   out_id;
      logic [OUT_DATA_W-1:0] out_data;
      logic [KCOUNT_W-1:0]   key_count;
      logic                  last;
   } key_rsp_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [15:0]         key_id;
      logic [63:0]         key_data;
      logic                fixed;
      logic [STATUS_W-1:0] status;
      logic [KCOUNT_W-1:0] key_count;
   } req_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic        rsp_tlast;

   // slot-level copy of the key store
   logic [15:0] slot_key_id   [SLOTS];
   logic [63:0] slot_key_data [SLOTS];
   int          stored_keys;

   key_rsp_type pending_rsp [$];
   req_row_type req_rows    [$];
   logic [15:0] id_pool     [ID_POOL_N];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int request_count;
   int result_count;
   int full_hits;
   int long_lists;

   key_slot_table_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Timeout at %0t with %0d results outstanding", $realtime,
               pending_rsp.size());
      $display("Mismatches found");
      $finish;
   end

   function automatic int find_key_slot(logic [15:0] id);
      if (id == 16'd0) return -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot_key_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void push_rsp(logic [STATUS_W-1:0] st, logic [15:0] id,
                                    logic [63:0] data, logic last);
      key_rsp_type r;
      r.status    = st;
      r.out_id    = id;
      r.out_data  = data;
      r.key_count = stored_keys[KCOUNT_W-1:0];
      r.last      = last;
      pending_rsp = {pending_rsp, r};
      if (st == ST_FULL) full_hits++;
   endfunction

   // Apply one request to the slot copy and queue the results it produces.
   function automatic void apply_key_request(logic [FUNC_W-1:0] func, logic [15:0] id,
                                             logic [63:0] data);
      int          s;
      int          n;
      logic [15:0] listed [SLOTS];
      s = find_key_slot(id);
      n = 0;
      case (func)
         OP_INJECT: begin
            if (id == 16'd0) push_rsp(ST_BAD_ID, 16'd0, 64'd0, 1'b1);
            else if (stored_keys >= SLOTS) push_rsp(ST_FULL, 16'd0, 64'd0, 1'b1);
            else if (s >= 0) push_rsp(ST_DUP_ID, 16'd0, 64'd0, 1'b1);
            else if (data == 64'd0) push_rsp(ST_EMPTY, 16'd0, 64'd0, 1'b1);
            else begin
               // take the lowest free slot
               for (int i = 0; i < SLOTS; i++) begin
                  if (n == 0 && slot_key_id[i] == 16'd0) begin
                     slot_key_id[i]   = id;
                     slot_key_data[i] = data;
                     n = 1;
                  end
               end
               stored_keys++;
               push_rsp(ST_OK, 16'd0, 64'd0, 1'b1);
            end
         end
         OP_ERASE: begin
            if (s < 0) push_rsp(ST_BAD_ID, 16'd0, 64'd0, 1'b1);
            else begin
               slot_key_id[s]   = 16'd0;
               slot_key_data[s] = 64'd0;
               if (stored_keys > 0) stored_keys--;
               push_rsp(ST_OK, 16'd0, 64'd0, 1'b1);
            end
         end
         OP_UPDATE: begin
            if (data == 64'd0) push_rsp(ST_EMPTY, 16'd0, 64'd0, 1'b1);
            else if (s < 0) push_rsp(ST_BAD_ID, 16'd0, 64'd0, 1'b1);
            else if (slot_key_data[s] == data) push_rsp(ST_DUP_DATA, 16'd0, 64'd0, 1'b1);
            else begin
               slot_key_data[s] = data;
               push_rsp(ST_OK, 16'd0, 64'd0, 1'b1);
            end
         end
         OP_GET: begin
            if (s < 0) push_rsp(ST_BAD_ID, 16'd0, 64'd0, 1'b1);
            else push_rsp(ST_OK, 16'd0, slot_key_data[s], 1'b1);
         end
         OP_LIST: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_key_id[i] != 16'd0 && n < MAX_RESULTS) begin
                  listed[n] = slot_key_id[i];
                  n++;
               end
            end
            if (n == 0) push_rsp(ST_OK, 16'd0, 64'd0, 1'b1);
            for (int k = 0; k < n; k++)
               push_rsp(ST_OK, listed[k], 64'd0, k == n - 1);
            if (n == MAX_RESULTS) long_lists++;
         end
         default: push_rsp(ST_BAD_ID, 16'd0, 64'd0, 1'b1);
      endcase
   endfunction

   // Present one request and hold it until the transfer completes.
   task automatic send_request(logic [FUNC_W-1:0] func, logic [15:0] id,
                               logic [63:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, data, id, func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
   endtask

   task automatic add_row(logic [FUNC_W-1:0] func, logic [15:0] id, logic [63:0] data,
                          logic fixed, logic [STATUS_W-1:0] st,
                          logic [KCOUNT_W-1:0] cnt);
      req_row_type r;
      r.func      = func;
      r.key_id    = id;
      r.key_data  = data;
      r.fixed     = fixed;
      r.status    = st;
      r.key_count = cnt;
      req_rows    = {req_rows, r};
   endtask

   function automatic logic [15:0] pick_key_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return 16'd0;
      if (r < 14) return 16'($urandom_range(1, 65535));
      return id_pool[$urandom_range(0, ID_POOL_N - 1)];
   endfunction

   function automatic logic [63:0] pick_key_data(logic [FUNC_W-1:0] func, logic [15:0] id);
      int r;
      int s;
      r = $urandom_range(0, 99);
      s = find_key_slot(id);
      if (r < 8) return 64'd0;
      // reuse the stored data to hit the duplicate-data case
      if (func == OP_UPDATE && s >= 0 && r < 30) return slot_key_data[s];
      return {$urandom, $urandom};
   endfunction

   // First half of a phase leans on inject to fill the table, second half on erase.
   task automatic run_random_phase(int send_pct, int recv_pct, int count);
      int                r;
      logic [FUNC_W-1:0] func;
      logic [15:0]       id;
      logic [63:0]       data;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 4) func = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
         else if (k < count / 2) begin
            if (r < 60) func = OP_INJECT;
            else if (r < 72) func = OP_UPDATE;
            else if (r < 82) func = OP_GET;
            else if (r < 90) func = OP_ERASE;
            else func = OP_LIST;
         end else begin
            if (r < 15) func = OP_INJECT;
            else if (r < 60) func = OP_ERASE;
            else if (r < 72) func = OP_UPDATE;
            else if (r < 84) func = OP_GET;
            else func = OP_LIST;
         end
         id   = pick_key_id();
         data = pick_key_data(func, id);
         send_request(func, id, data);
         apply_key_request(func, id, data);
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      end
   endtask

   // Compare each result transfer with the oldest queued expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (pending_rsp.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual %0h last %0b",
                        $realtime, rsp_tdata, rsp_tlast);
            end else begin
               check_field("status", 64'(pending_rsp[0].status), 64'(rsp_tdata[2:0]));
               check_field("out_id", 64'(pending_rsp[0].out_id), 64'(rsp_tdata[18:3]));
               check_field("out_data", pending_rsp[0].out_data, rsp_tdata[82:19]);
               check_field("key_count", 64'(pending_rsp[0].key_count),
                           64'(rsp_tdata[87:83]));
               check_field("last", 64'(pending_rsp[0].last), 64'(rsp_tlast));
               void'(pending_rsp.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      key_rsp_type fixed_rsp;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      send_idle_pct = 25;
      recv_idle_pct = 87;
      error_count   = 0;
      request_count = 0;
      result_count  = 0;
      full_hits     = 0;
      long_lists    = 0;
      stored_keys   = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_key_id[i]   = 16'd0;
         slot_key_data[i] = 64'd0;
      end
      id_pool[0] = 16'hFFFF;
      id_pool[1] = 16'h0001;
      for (int i = 2; i < ID_POOL_N; i++) id_pool[i] = 16'($urandom_range(1, 65535));

      add_row(OP_LIST,   16'h0000, 64'h0,                   1'b1, ST_OK,       5'd0);
      add_row(OP_GET,    16'h0000, 64'h0,                   1'b1, ST_BAD_ID,   5'd0);
      add_row(OP_ERASE,  16'h0000, 64'h0,                   1'b1, ST_BAD_ID,   5'd0);
      add_row(OP_UPDATE, 16'h0000, 64'h0,                   1'b1, ST_EMPTY,    5'd0);
      add_row(OP_UPDATE, 16'h0000, 64'h1,                   1'b1, ST_BAD_ID,   5'd0);
      add_row(OP_INJECT, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_BAD_ID,   5'd0);
      add_row(OP_INJECT, 16'h0001, 64'h0,                   1'b1, ST_EMPTY,    5'd0);
      add_row(OP_INJECT, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK,       5'd1);
      add_row(OP_INJECT, 16'h0001, 64'h1,                   1'b1, ST_DUP_ID,   5'd1);
      add_row(OP_INJECT, 16'hFFFF, 64'h1,                   1'b1, ST_OK,       5'd2);
      add_row(OP_GET,    16'hFFFF, 64'h0,                   1'b0, ST_OK,       5'd0);
      add_row(OP_GET,    16'h0001, 64'h0,                   1'b0, ST_OK,       5'd0);
      add_row(OP_UPDATE, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_DUP_DATA, 5'd2);
      add_row(OP_UPDATE, 16'h0001, 64'h5555_5555_5555_5555, 1'b1, ST_OK,       5'd2);
      add_row(OP_UPDATE, 16'h0007, 64'h1,                   1'b1, ST_BAD_ID,   5'd2);
      add_row(OP_GET,    16'h0007, 64'h0,                   1'b1, ST_BAD_ID,   5'd2);
      add_row(OP_SPARE5, 16'h0001, 64'h0,                   1'b1, ST_BAD_ID,   5'd2);
      add_row(OP_SPARE6, 16'h0001, 64'h1,                   1'b1, ST_BAD_ID,   5'd2);
      add_row(OP_SPARE7, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_BAD_ID,   5'd2);
      add_row(OP_ERASE,  16'hFFFF, 64'h0,                   1'b1, ST_OK,       5'd1);
      add_row(OP_ERASE,  16'hFFFF, 64'h0,                   1'b1, ST_BAD_ID,   5'd1);
      add_row(OP_INJECT, 16'h0002, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_OK,       5'd2);
      add_row(OP_LIST,   16'h0000, 64'h0,                   1'b0, ST_OK,       5'd0);
      add_row(OP_INJECT, 16'hFFFF, 64'h8000_0000_0000_0000, 1'b1, ST_OK,       5'd3);
      add_row(OP_LIST,   16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK,       5'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (req_rows[i]) begin
         send_request(req_rows[i].func, req_rows[i].key_id, req_rows[i].key_data);
         apply_key_request(req_rows[i].func, req_rows[i].key_id, req_rows[i].key_data);
         if (req_rows[i].fixed) begin
            fixed_rsp.status    = req_rows[i].status;
            fixed_rsp.out_id    = 16'd0;
            fixed_rsp.out_data  = 64'd0;
            fixed_rsp.key_count = req_rows[i].key_count;
            fixed_rsp.last      = 1'b1;
            pending_rsp[pending_rsp.size() - 1] = fixed_rsp;
         end
      end

      run_random_phase(25, 87, RAND_N);
      run_random_phase(87, 25, RAND_N);
      run_random_phase(0, 0, RAND_N);
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      // let a trailing list or stray result show up
      repeat (SLOTS + 8) @(posedge clock);

      $display("Sent %0d requests and checked %0d results", request_count, result_count);
      $display("Table-full answers: %0d, full-length lists: %0d", full_hits, long_lists);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: key_slot_table_unit.f
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_cell.sv
rtl/core/key_slot_table_unit.sv
test/key_slot_table_unit_test.sv
